>>> hdl/rpfc_pkg.sv
// Shared types and constants for the random-prefix frame checker.
// No dependencies; imported by every module of the block.
package rpfc_pkg;

  // Frame layout
  localparam int unsigned MAX_FRAME_BYTES = 65536;
  localparam int unsigned HDR_LEN         = 8;
  localparam int unsigned WIN_LEN         = 16;
  localparam logic [7:0]  PAD_MASK        = 8'h07;

  // Byte counter holds up to MAX_FRAME_BYTES + 1, and the frame size one more
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 3);
  // Width used for the payload length before it is clipped to 16 bits
  localparam int unsigned LEN_W = (CNT_W > 17) ? CNT_W : 17;

  // Result FIFO
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
    logic        run_last;
  } result_t;

  // Up to two results raised by one accepted request
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } core_res_t;

endpackage

>>> hdl/rpfc_frame_core.sv
// Frame state (header, sixteen-byte window, byte count) and per-request result logic.
// Depends on rpfc_pkg.
module rpfc_frame_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic [7:0]         frame_byte_i,
  input  logic               frame_end_i,
  output rpfc_pkg::core_res_t res_o
);
  import rpfc_pkg::*;

  logic [7:0]       header_q [HDR_LEN];
  logic [7:0]       recent_q [WIN_LEN];
  logic [7:0]       recent_n [WIN_LEN];
  logic [CNT_W-1:0] count_q, count_d;
  logic [2:0]       pad_q, pad_d;
  logic [CNT_W-1:0] size;
  logic [CNT_W-1:0] emit_from;
  logic [LEN_W-1:0] len_full;
  logic [15:0]      len_clip;
  logic             emit;
  logic             check_ok;
  logic             frame_ok;
  result_t          pay_res, ver_res;

  // Window as it stands after this byte is shifted in
  always_comb begin
    recent_n[0] = frame_byte_i;
    for (int i = 1; i < WIN_LEN; i++) recent_n[i] = recent_q[i-1];
  end

  // Padding count is taken from header byte 7
  always_comb begin
    pad_d = pad_q;
    if (count_q == CNT_W'(HDR_LEN - 1)) pad_d = frame_byte_i[2:0] & PAD_MASK[2:0];
  end

  assign size      = count_q + CNT_W'(1);
  assign emit_from = CNT_W'(WIN_LEN) + CNT_W'(pad_d);
  assign emit      = (count_q >= emit_from);

  // Check bytes against header XOR the bytes before the check
  always_comb begin
    check_ok = 1'b1;
    for (int i = 0; i < HDR_LEN; i++) begin
      if (recent_n[HDR_LEN-1-i] != (header_q[i] ^ recent_n[HDR_LEN+i])) check_ok = 1'b0;
    end
  end

  assign len_full = LEN_W'(size) - LEN_W'(WIN_LEN) - LEN_W'(pad_d);
  assign len_clip = (len_full[LEN_W-1:16] != '0) ? 16'hffff : len_full[15:0];
  assign frame_ok = (size >= CNT_W'(WIN_LEN)) && (size <= CNT_W'(MAX_FRAME_BYTES))
                  && (size > emit_from) && check_ok;

  // Result items
  always_comb begin
    pay_res.kind           = KIND_PAYLOAD;
    pay_res.payload_byte   = recent_n[HDR_LEN];
    pay_res.payload_length = '0;
    pay_res.run_last       = ~frame_end_i;
    ver_res.kind           = frame_ok ? KIND_ACCEPT : KIND_REJECT;
    ver_res.payload_byte   = '0;
    ver_res.payload_length = frame_ok ? len_clip : 16'd0;
    ver_res.run_last       = 1'b1;

    res_o.res1 = ver_res;
    if (emit) begin
      res_o.res0  = pay_res;
      res_o.count = frame_end_i ? 2'd2 : 2'd1;
    end else begin
      res_o.res0  = ver_res;
      res_o.count = frame_end_i ? 2'd1 : 2'd0;
    end
    if (!take_i) res_o.count = 2'd0;
  end

  // Counter with saturation, cleared after the final byte
  always_comb begin
    count_d = count_q;
    if (frame_end_i)                                count_d = '0;
    else if (count_q < CNT_W'(MAX_FRAME_BYTES + 1)) count_d = size;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pad_q   <= '0;
    end else if (take_i) begin
      count_q <= count_d;
      pad_q   <= frame_end_i ? 3'd0 : pad_d;
    end
  end

  // Byte stores; every read of them follows a write in the same frame
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      for (int i = 0; i < WIN_LEN; i++) recent_q[i] <= recent_n[i];
      if (count_q < CNT_W'(HDR_LEN)) header_q[count_q[2:0]] <= frame_byte_i;
    end
  end

endmodule

>>> hdl/rpfc_result_fifo.sv
// Four-entry result queue; takes up to two results a cycle, gives one while ready_i is high.
// Depends on rpfc_pkg.
module rpfc_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpfc_pkg::core_res_t push_i,
  output logic                room2_o,
  output logic                valid_o,
  input  logic                ready_i,
  output rpfc_pkg::result_t   data_o
);
  import rpfc_pkg::*;

  result_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;
  logic               pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign pop     = valid_o && ready_i;
  assign room2_o = (cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2));

  // Pointer and fill count
  always_comb begin
    wptr_d = wptr_q + FIFO_AW'(push_i.count);
    rptr_d = rptr_q + FIFO_AW'(pop);
    cnt_d  = cnt_q + (FIFO_AW+1)'(push_i.count) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry writes
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wptr_q] <= push_i.res0;
    if (push_i.count == 2'd2) mem_q[wptr_q + FIFO_AW'(1)] <= push_i.res1;
  end

endmodule

>>> hdl/random_prefix_frame_checker_unit.sv
// Top level of the random-prefix frame checker: frame core feeding a result queue.
// Depends on rpfc_pkg, rpfc_frame_core and rpfc_result_fifo.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------------------
//   in      | input     | in_valid_i / in_ready_o | frame_byte_i, frame_end_i
//   out     | output    | out_valid_o/out_ready_i | kind_o, payload_byte_o, payload_length_o,
//           |           |                         | run_last_o
//
// One frame byte is taken per cycle while in_ready_o is high; its results are written
// into a four-entry queue at the same edge and can leave from the next cycle, one per
// cycle while out_ready_i is high. A final byte that also releases a payload byte
// raises two results, so the output side must hand out both; in_ready_o drops while
// fewer than two queue slots are free. Reset clears the frame counter, padding count,
// queue pointers and fill count; nothing else needs clearing.
module random_prefix_frame_checker_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          frame_byte_i,
  input  logic                frame_end_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rpfc_pkg::kind_e     kind_o,
  output logic [7:0]          payload_byte_o,
  output logic [15:0]         payload_length_o,
  output logic                run_last_o
);
  import rpfc_pkg::*;

  core_res_t core_res;
  result_t   head;
  logic      room2;
  logic      take;

  assign in_ready_o = room2;
  assign take       = in_valid_i && room2;

  rpfc_frame_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .frame_byte_i (frame_byte_i),
    .frame_end_i  (frame_end_i),
    .res_o        (core_res)
  );

  rpfc_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (core_res),
    .room2_o (room2),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (head)
  );

  assign kind_o           = head.kind;
  assign payload_byte_o   = head.payload_byte;
  assign payload_length_o = head.payload_length;
  assign run_last_o       = head.run_last;

endmodule

>>> hdl/rpfc_checker.sv
// Port-level checks for the random-prefix frame checker, bound to the top level.
// Depends on rpfc_pkg and random_prefix_frame_checker_unit.
module rpfc_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input rpfc_pkg::kind_e kind_o,
  input logic [7:0]      payload_byte_o,
  input logic [15:0]     payload_length_o,
  input logic            run_last_o
);
  import rpfc_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(payload_byte_o) && $stable(payload_length_o))
    else $error("output result changed while stalled");

  // Payload items carry no length
  a_pay_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PAYLOAD |-> payload_length_o == 16'd0)
    else $error("payload item with non-zero length");

  // A verdict is always the last result of its request
  a_ver_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_ACCEPT || kind_o == KIND_REJECT) |-> run_last_o
      && payload_byte_o == 8'd0)
    else $error("verdict without run_last or with a byte");

  // Rejected and accepted verdicts carry consistent lengths
  a_ver_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_PAYLOAD |->
      ((kind_o == KIND_REJECT) == (payload_length_o == 16'd0)))
    else $error("verdict length inconsistent with its kind");

endmodule

bind random_prefix_frame_checker_unit rpfc_checker u_rpfc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .kind_o           (kind_o),
  .payload_byte_o   (payload_byte_o),
  .payload_length_o (payload_length_o),
  .run_last_o       (run_last_o)
);

>>> test/random_prefix_frame_checker_unit_tb.sv
// Self-checking testbench for random_prefix_frame_checker_unit.
// Needs rpfc_pkg and the RTL of the block; a scoreboard class predicts results
// from accepted frame bytes, plain tasks drive and drain the two channels.
module random_prefix_frame_checker_unit_tb;
  import rpfc_pkg::*;

  typedef logic [7:0] octet_q_t [$];

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_BYTES = 700;
  localparam int unsigned CALM_AFTER = 600;
  localparam int unsigned HOLD_AT = 300;
  localparam int unsigned HOLD_CYCLES = 240;
  localparam int unsigned MAX_REPORTS = 30;

  // Frame predictor and result scoreboard
  class frame_scoreboard;
    logic [7:0] hdr_seen [HDR_LEN];
    logic [7:0] window [WIN_LEN];
    int unsigned taken;
    logic [2:0] pad_len;
    result_t pending [$];
    int unsigned errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      for (int i = 0; i < HDR_LEN; i++) hdr_seen[i] = '0;
      for (int i = 0; i < WIN_LEN; i++) window[i] = '0;
      taken = 0;
      pad_len = '0;
    endfunction

    task report_mismatch(input string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // One accepted request: update frame state, queue what it must produce
    function void note_request(input logic [7:0] data, input logic last_b);
      int unsigned pos;
      int unsigned size;
      int unsigned plen;
      bit ok;
      result_t r;
      pos = taken;
      size = pos + 1;
      for (int i = WIN_LEN - 1; i > 0; i--) window[i] = window[i - 1];
      window[0] = data;
      if (pos < HDR_LEN) begin
        hdr_seen[pos] = data;
        if (pos == HDR_LEN - 1) pad_len = data[2:0];
      end
      if (taken < MAX_FRAME_BYTES + 1) taken++;

      // payload byte, eight bytes late, once past header and padding
      if (pos >= WIN_LEN + pad_len) begin
        r.kind = KIND_PAYLOAD;
        r.payload_byte = window[8];
        r.payload_length = '0;
        r.run_last = !last_b;
        pending.push_back(r);
      end

      // verdict on the final byte
      if (last_b) begin
        ok = 1'b1;
        plen = 0;
        if (size < WIN_LEN || size > MAX_FRAME_BYTES || size <= WIN_LEN + pad_len) begin
          ok = 1'b0;
        end else begin
          plen = size - WIN_LEN - pad_len;
          for (int i = 0; i < HDR_LEN; i++)
            if (window[7 - i] != (hdr_seen[i] ^ window[8 + i])) ok = 1'b0;
        end
        if (plen > 65535) plen = 65535;
        r.kind = ok ? KIND_ACCEPT : KIND_REJECT;
        r.payload_byte = '0;
        r.payload_length = ok ? 16'(plen) : 16'd0;
        r.run_last = 1'b1;
        pending.push_back(r);
        clear_frame();
      end
    endfunction

    // One accepted result against the oldest expectation
    task check_result(input kind_e kind, input logic [7:0] data,
                      input logic [15:0] len, input logic last_b);
      result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %s", kind.name()));
      end else begin
        want = pending.pop_front();
        if (kind !== want.kind)
          report_mismatch($sformatf("kind %s, expected %s", kind.name(), want.kind.name()));
        if (data !== want.payload_byte)
          report_mismatch($sformatf("payload_byte %h, expected %h", data, want.payload_byte));
        if (len !== want.payload_length)
          report_mismatch($sformatf("payload_length %0d, expected %0d", len,
                                    want.payload_length));
        if (last_b !== want.run_last)
          report_mismatch($sformatf("run_last %b, expected %b", last_b, want.run_last));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [7:0] frame_byte_i;
  logic frame_end_i;
  logic out_valid_o;
  logic out_ready_i;
  kind_e kind_o;
  logic [7:0] payload_byte_o;
  logic [15:0] payload_length_o;
  logic run_last_o;

  frame_scoreboard sb;
  int unsigned cycle_count;
  bit calm;
  bit hold_request;
  int unsigned tx_gap_rate;

  random_prefix_frame_checker_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .frame_byte_i     (frame_byte_i),
    .frame_end_i      (frame_end_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .payload_byte_o   (payload_byte_o),
    .payload_length_o (payload_length_o),
    .run_last_o       (run_last_o)
  );

  // Clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result sampling
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(kind_o, payload_byte_o, payload_length_o, run_last_o);
  end

  // Receiver: random stall bursts, one long hold-off on request, none when calm
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned rx_rate;
    int unsigned phase_left;
    stall_left = 0;
    hold_left = 0;
    rx_rate = 0;
    phase_left = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (phase_left == 0) begin
        phase_left = 50;
        case ($urandom_range(0, 2))
          0: rx_rate = 0;
          1: rx_rate = 4;
          default: rx_rate = 10;
        endcase
      end
      phase_left--;
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (rx_rate != 0 && $urandom_range(1, rx_rate) == 1) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Offer one byte from a falling edge and hold it until taken
  task automatic send_byte(input logic [7:0] data, input logic last_b);
    in_valid_i <= 1'b1;
    frame_byte_i <= data;
    frame_end_i <= last_b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(data, last_b);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input octet_q_t f);
    for (int i = 0; i < f.size(); i++) begin
      send_byte(f[i], i == f.size() - 1);
      if (!calm && tx_gap_rate != 0 && $urandom_range(1, tx_gap_rate) == 1) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end
    end
  endtask

  // Header, padding, payload, then the check bytes; extremes alternates 00/FF
  function automatic octet_q_t make_frame(input int unsigned pad, input int unsigned body_len,
                                          input bit good, input bit extremes);
    octet_q_t f;
    logic [7:0] hdr [HDR_LEN];
    int unsigned n;
    int unsigned k;
    for (int i = 0; i < HDR_LEN; i++)
      hdr[i] = extremes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
    hdr[7] = {hdr[7][7:3], 3'(pad)};
    for (int i = 0; i < HDR_LEN; i++) f.push_back(hdr[i]);
    for (int i = 0; i < pad + body_len; i++)
      f.push_back(extremes ? ((f.size() % 2) ? 8'hFF : 8'h00) : 8'($urandom));
    n = f.size();
    for (int i = 0; i < HDR_LEN; i++) f.push_back(hdr[i] ^ f[n - 1 - i]);
    if (!good) begin
      k = $urandom_range(0, 7);
      f[n + k] = f[n + k] ^ (8'h01 << $urandom_range(0, 7));
    end
    return f;
  endfunction

  function automatic octet_q_t noise_frame(input int unsigned len);
    octet_q_t f;
    for (int i = 0; i < len; i++) f.push_back(8'($urandom));
    return f;
  endfunction

  // Stimulus
  initial begin
    octet_q_t f;
    int unsigned sent;
    int unsigned pick;
    int unsigned pad;
    bit hold_done;
    sb = new();
    cycle_count = 0;
    calm = 1'b0;
    hold_request = 1'b0;
    tx_gap_rate = 4;
    hold_done = 1'b0;
    sent = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    frame_byte_i = '0;
    frame_end_i = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: short frames, empty payloads, minimal and extreme frames, bad check
    f = {8'hFF};
    send_frame(f);
    f = make_frame(0, 1, 1, 1);
    f = f[0:14];
    send_frame(f);
    send_frame(make_frame(0, 0, 1, 0));
    send_frame(make_frame(7, 0, 1, 0));
    send_frame(make_frame(0, 1, 1, 1));
    send_frame(make_frame(7, 3, 1, 1));
    send_frame(make_frame(7, 3, 0, 1));
    send_frame(make_frame(3, 5, 1, 0));

    // Random frames: mostly well formed, some corrupted, short or noise
    while (sent < RANDOM_BYTES) begin
      pad = $urandom_range(0, 7);
      case ($urandom_range(0, 2))
        0: tx_gap_rate = 0;
        1: tx_gap_rate = 3;
        default: tx_gap_rate = 8;
      endcase
      if (!hold_done && sent >= HOLD_AT) begin
        // long receiver hold-off while this frame keeps coming
        hold_done = 1'b1;
        hold_request = 1'b1;
        tx_gap_rate = 0;
        f = make_frame(pad, 40, 1, 0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65)
          f = make_frame(pad, ($urandom_range(0, 9) == 0) ? $urandom_range(21, 60)
                                                          : $urandom_range(1, 20), 1, 0);
        else if (pick < 77)
          f = make_frame(pad, $urandom_range(1, 20), 0, 0);
        else if (pick < 88)
          f = noise_frame($urandom_range(1, 30));
        else if (pick < 94)
          f = make_frame(pad, 0, $urandom_range(0, 1), 0);
        else
          f = noise_frame($urandom_range(1, WIN_LEN - 1));
      end
      if (sent >= CALM_AFTER) calm = 1'b1;
      send_frame(f);
      sent += f.size();
    end
    in_valid_i <= 1'b0;

    // Drain, then allow a few more cycles for stray results
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
